// File: rtl/tlpq_pkg.sv
package tlpq_pkg;

    localparam int CAPACITY   = 64;
    localparam int NUM_LEVELS = 3;

    localparam int LVL_W   = $clog2(NUM_LEVELS);
    localparam int PTR_W   = $clog2(CAPACITY);
    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int DEPTH   = NUM_LEVELS * CAPACITY;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int AGE_W   = 8;
    localparam int TAG_W   = 16;
    localparam int ENTRY_W = AGE_W + TAG_W;

    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_DEQUEUE = 1'b1;

    localparam logic [1:0] STATUS_ENQUEUED = 2'd0;
    localparam logic [1:0] STATUS_DEQUEUED = 2'd1;
    localparam logic [1:0] STATUS_EMPTY    = 2'd2;
    localparam logic [1:0] STATUS_FULL     = 2'd3;

    typedef struct packed {
        logic             opcode;
        logic [1:0]       prio_level;
        logic [AGE_W-1:0] age_years;
        logic [TAG_W-1:0] entry_tag;
    } in_item_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [1:0]       out_level;
        logic [AGE_W-1:0] out_age;
        logic [TAG_W-1:0] out_tag;
    } out_item_t;

    // each level owns CAPACITY consecutive slots of the shared store
    function automatic logic [ADDR_W-1:0] slot_addr(input logic [LVL_W-1:0] idx,
                                                   input logic [PTR_W-1:0] ptr);
        slot_addr = ADDR_W'(idx) * ADDR_W'(CAPACITY) + ADDR_W'(ptr);
    endfunction

    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] ptr);
        if (ptr == PTR_W'(CAPACITY - 1)) begin
            next_slot = '0;
        end else begin
            next_slot = ptr + PTR_W'(1);
        end
    endfunction

endpackage

// File: rtl/tlpq_ram.sv
module tlpq_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 192
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: rtl/three_level_priority_queue_core.sv
// Three-level strict-priority queue, FIFO order within a level.
// Input channel s_valid/s_ready/s_item carries one command per transaction:
// enqueue (level, age, tag) or dequeue. Result channel m_valid/m_ready/m_item
// returns exactly one result per command, in command order.
// Entries live in a single-port-per-direction RAM of 3*CAPACITY words, one
// region per level; head, tail and count per level sit in flops.
// Timing: enqueue, full and empty answers are registered after the command
// is taken; a dequeue with data first passes through ST_READ, for the
// registered read of the entry RAM. A new command can be taken in the cycle
// its predecessor's result is taken, so enqueues sustain one per cycle while
// m_ready is high; no command is taken while a dequeue is in ST_READ.
// Stalls: a result waits in the output register until m_ready; while it
// waits and is not being taken, s_ready stays low.
// Reset (aresetn low, synchronous): all levels empty, pointers at slot 0,
// no result pending. RAM contents are not cleared; no clearing pass is needed
// because only slots holding live entries are ever read.
module three_level_priority_queue_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  tlpq_pkg::in_item_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output tlpq_pkg::out_item_t m_item
);

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } state_t;

    state_t state_reg, state_next;

    logic [tlpq_pkg::PTR_W-1:0] head_reg  [tlpq_pkg::NUM_LEVELS];
    logic [tlpq_pkg::PTR_W-1:0] head_next [tlpq_pkg::NUM_LEVELS];
    logic [tlpq_pkg::PTR_W-1:0] tail_reg  [tlpq_pkg::NUM_LEVELS];
    logic [tlpq_pkg::PTR_W-1:0] tail_next [tlpq_pkg::NUM_LEVELS];
    logic [tlpq_pkg::CNT_W-1:0] count_reg [tlpq_pkg::NUM_LEVELS];
    logic [tlpq_pkg::CNT_W-1:0] count_next[tlpq_pkg::NUM_LEVELS];
    logic [tlpq_pkg::CNT_W-1:0] total_reg, total_next;

    logic                m_valid_reg, m_valid_next;
    tlpq_pkg::out_item_t m_item_reg, m_item_next;
    logic [1:0]          deq_level_reg, deq_level_next;

    logic                         accept;
    logic [tlpq_pkg::LVL_W-1:0]   enq_idx;
    logic [tlpq_pkg::LVL_W-1:0]   deq_idx;

    logic                         ram_we;
    logic [tlpq_pkg::ADDR_W-1:0]  ram_waddr;
    logic [tlpq_pkg::ENTRY_W-1:0] ram_wdata;
    logic                         ram_re;
    logic [tlpq_pkg::ADDR_W-1:0]  ram_raddr;
    logic [tlpq_pkg::ENTRY_W-1:0] ram_rdata;

    tlpq_ram #(
        .WIDTH(tlpq_pkg::ENTRY_W),
        .DEPTH(tlpq_pkg::DEPTH)
    ) u_store (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign s_ready = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    // level 0 is treated as level 1, the most urgent level
    assign enq_idx = (s_item.prio_level == 2'd0) ? '0
                   : tlpq_pkg::LVL_W'(s_item.prio_level - 2'd1);

    always_comb begin
        priority if (count_reg[0] != '0) begin
            deq_idx = tlpq_pkg::LVL_W'(0);
        end else if (count_reg[1] != '0) begin
            deq_idx = tlpq_pkg::LVL_W'(1);
        end else begin
            deq_idx = tlpq_pkg::LVL_W'(2);
        end
    end

    always_comb begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        total_next     = total_reg;
        m_valid_next   = m_valid_reg;
        m_item_next    = m_item_reg;
        deq_level_next = deq_level_reg;
        ram_we         = 1'b0;
        ram_waddr      = tlpq_pkg::slot_addr(enq_idx, tail_reg[enq_idx]);
        ram_wdata      = {s_item.age_years, s_item.entry_tag};
        ram_re         = 1'b0;
        ram_raddr      = tlpq_pkg::slot_addr(deq_idx, head_reg[deq_idx]);

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    m_item_next = '0;
                    if (s_item.opcode == tlpq_pkg::OP_ENQUEUE) begin
                        m_valid_next = 1'b1;
                        if (total_reg >= tlpq_pkg::CNT_W'(tlpq_pkg::CAPACITY)) begin
                            m_item_next.status = tlpq_pkg::STATUS_FULL;
                        end else begin
                            m_item_next.status  = tlpq_pkg::STATUS_ENQUEUED;
                            ram_we              = 1'b1;
                            tail_next[enq_idx]  = tlpq_pkg::next_slot(tail_reg[enq_idx]);
                            count_next[enq_idx] = count_reg[enq_idx] + 1'b1;
                            total_next          = total_reg + 1'b1;
                        end
                    end else if (total_reg == '0) begin
                        m_valid_next       = 1'b1;
                        m_item_next.status = tlpq_pkg::STATUS_EMPTY;
                    end else begin
                        // result goes out once the RAM read returns
                        ram_re              = 1'b1;
                        head_next[deq_idx]  = tlpq_pkg::next_slot(head_reg[deq_idx]);
                        count_next[deq_idx] = count_reg[deq_idx] - 1'b1;
                        total_next          = total_reg - 1'b1;
                        deq_level_next      = 2'(deq_idx) + 2'd1;
                        state_next          = ST_READ;
                    end
                end
            end
            ST_READ: begin
                m_valid_next          = 1'b1;
                m_item_next.status    = tlpq_pkg::STATUS_DEQUEUED;
                m_item_next.out_level = deq_level_reg;
                m_item_next.out_age   = ram_rdata[tlpq_pkg::ENTRY_W-1:tlpq_pkg::TAG_W];
                m_item_next.out_tag   = ram_rdata[tlpq_pkg::TAG_W-1:0];
                state_next            = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            total_reg   <= '0;
            for (int i = 0; i < tlpq_pkg::NUM_LEVELS; i++) begin
                head_reg[i]  <= '0;
                tail_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            total_reg   <= total_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            count_reg   <= count_next;
        end
        m_item_reg    <= m_item_next;
        deq_level_reg <= deq_level_next;
    end

`ifndef NO_ASSERTIONS
    a_total_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        total_reg <= tlpq_pkg::CNT_W'(tlpq_pkg::CAPACITY))
        else $error("occupancy above capacity");

    a_total_matches_levels: assert property (@(posedge aclk) disable iff (!aresetn)
        total_reg == count_reg[0] + count_reg[1] + count_reg[2])
        else $error("total occupancy disagrees with level counts");

    a_out_free_on_read: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_READ |-> !m_valid_reg)
        else $error("read data returned with result register still occupied");

    a_deq_goes_to_read: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_item.opcode == tlpq_pkg::OP_DEQUEUE && total_reg != '0
        |=> state_reg == ST_READ)
        else $error("dequeue with data did not start a read");

    a_deq_level_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_item_reg.status == tlpq_pkg::STATUS_DEQUEUED
        |-> m_item_reg.out_level != 2'd0)
        else $error("dequeued result without a level");
`endif

endmodule
